// ===== rtl/fmbq_pkg.sv =====
// Shared constants, codes and control types for the front-middle-back queue.
package fmbq_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        KIND_PUSH_FRONT  = 3'd0,
        KIND_PUSH_MIDDLE = 3'd1,
        KIND_PUSH_BACK   = 3'd2,
        KIND_POP_FRONT   = 3'd3,
        KIND_POP_MIDDLE  = 3'd4,
        KIND_POP_BACK    = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Per-item command broadcast to every cell of the row.
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [IDX_W-1:0] pos;
        status_t          status;
    } op_t;

endpackage

// ===== rtl/fmbq_ctrl.sv =====
// Decodes an item against the entry count into the shift command for the cell row.
module fmbq_ctrl (
    input  logic [2:0]                 kind,
    input  logic [fmbq_pkg::CNT_W-1:0] count,
    output fmbq_pkg::op_t              op
);

    logic is_full;
    logic is_empty;

    assign is_full  = (count == fmbq_pkg::CNT_W'(fmbq_pkg::CAPACITY));
    assign is_empty = (count == '0);

    always_comb begin
        op.ins    = 1'b0;
        op.rem    = 1'b0;
        op.pos    = '0;
        op.status = fmbq_pkg::ST_DONE;
        case (fmbq_pkg::kind_t'(kind))
            fmbq_pkg::KIND_PUSH_FRONT,
            fmbq_pkg::KIND_PUSH_MIDDLE,
            fmbq_pkg::KIND_PUSH_BACK: begin
                if (is_full) begin
                    op.status = fmbq_pkg::ST_FULL;
                end else begin
                    op.ins = 1'b1;
                end
            end
            fmbq_pkg::KIND_POP_FRONT,
            fmbq_pkg::KIND_POP_MIDDLE,
            fmbq_pkg::KIND_POP_BACK: begin
                if (is_empty) begin
                    op.status = fmbq_pkg::ST_EMPTY;
                end else begin
                    op.rem = 1'b1;
                end
            end
            default: begin
            end
        endcase

        case (fmbq_pkg::kind_t'(kind))
            fmbq_pkg::KIND_PUSH_FRONT:  op.pos = '0;
            fmbq_pkg::KIND_PUSH_MIDDLE: op.pos = fmbq_pkg::IDX_W'(count >> 1);
            fmbq_pkg::KIND_PUSH_BACK:   op.pos = count[fmbq_pkg::IDX_W-1:0];
            fmbq_pkg::KIND_POP_FRONT:   op.pos = '0;
            fmbq_pkg::KIND_POP_MIDDLE:  op.pos = fmbq_pkg::IDX_W'((count - 1'b1) >> 1);
            fmbq_pkg::KIND_POP_BACK:    op.pos = fmbq_pkg::IDX_W'(count - 1'b1);
            default:                    op.pos = '0;
        endcase
    end

endmodule

// ===== rtl/fmbq_cell.sv =====
// One queue slot: holds a value and shifts towards either neighbour on command.
module fmbq_cell (
    input  logic                        aclk,
    input  fmbq_pkg::op_t               op,
    input  logic                        step,
    input  logic [fmbq_pkg::IDX_W-1:0]  cell_idx,
    input  logic [fmbq_pkg::DATA_W-1:0] push_value,
    input  logic [fmbq_pkg::DATA_W-1:0] left_value,
    input  logic [fmbq_pkg::DATA_W-1:0] right_value,
    output logic [fmbq_pkg::DATA_W-1:0] value,
    output logic [fmbq_pkg::DATA_W-1:0] sel_value
);

    logic [fmbq_pkg::DATA_W-1:0] value_reg;
    logic [fmbq_pkg::DATA_W-1:0] value_next;
    logic                        at_pos;
    logic                        past_pos;

    assign at_pos   = (cell_idx == op.pos);
    assign past_pos = (cell_idx > op.pos);

    always_comb begin
        value_next = value_reg;
        if (step && op.ins) begin
            if (past_pos) begin
                value_next = left_value;
            end else if (at_pos) begin
                value_next = push_value;
            end
        end else if (step && op.rem) begin
            // close the gap: everything from the removed slot onward moves forward
            if (past_pos || at_pos) begin
                value_next = right_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value     = value_reg;
    assign sel_value = at_pos ? value_reg : '0;

endmodule

// ===== rtl/front_middle_back_queue.sv =====
// Front-middle-back queue built as a row of shifting cells, one entry per cell.
// The result of an item is presented in the cycle after it is accepted.
// Throughput: one item per cycle while the held result is taken; the count and every cell update in the accept cycle.
// The output register lets a new item in whenever the held result is taken that cycle.
// Reset (synchronous, active low) empties the queue and drops any held result;
// cell contents are not cleared.
module front_middle_back_queue (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [2:0]                  s_kind,
    input  logic signed [31:0]          s_push_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [31:0]          m_pop_value,
    output logic [1:0]                  m_status
);

    localparam int N = fmbq_pkg::CAPACITY;

    logic [fmbq_pkg::CNT_W-1:0]  count_reg;
    logic [fmbq_pkg::CNT_W-1:0]  count_next;
    logic                        m_valid_reg;
    logic                        m_valid_next;
    logic [fmbq_pkg::DATA_W-1:0] pop_value_reg;
    logic [fmbq_pkg::DATA_W-1:0] pop_value_next;
    logic [1:0]                  status_reg;
    logic [1:0]                  status_next;

    fmbq_pkg::op_t               op;
    logic                        step;
    logic [fmbq_pkg::DATA_W-1:0] cell_value [N];
    logic [fmbq_pkg::DATA_W-1:0] cell_sel   [N];
    logic [fmbq_pkg::DATA_W-1:0] read_value;

    // take no item while reset is held
    assign s_ready = aresetn && (!m_valid_reg || m_ready);
    assign step    = s_valid && s_ready;

    fmbq_ctrl u_ctrl (
        .kind  (s_kind),
        .count (count_reg),
        .op    (op)
    );

    for (genvar i = 0; i < N; i++) begin : g_cell
        logic [fmbq_pkg::DATA_W-1:0] left_value;
        logic [fmbq_pkg::DATA_W-1:0] right_value;

        if (i == 0) begin : g_first
            assign left_value = '0;
        end else begin : g_left
            assign left_value = cell_value[i-1];
        end

        if (i == N - 1) begin : g_last
            assign right_value = '0;
        end else begin : g_right
            assign right_value = cell_value[i+1];
        end

        fmbq_cell u_cell (
            .aclk        (aclk),
            .op          (op),
            .step        (step),
            .cell_idx    (fmbq_pkg::IDX_W'(i)),
            .push_value  (s_push_value),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[i]),
            .sel_value   (cell_sel[i])
        );
    end

    // only the addressed cell drives a non-zero word
    always_comb begin
        read_value = '0;
        for (int i = 0; i < N; i++) begin
            read_value = read_value | cell_sel[i];
        end
    end

    always_comb begin
        count_next     = count_reg;
        m_valid_next   = m_valid_reg;
        pop_value_next = pop_value_reg;
        status_next    = status_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (step) begin
            m_valid_next = 1'b1;
            status_next  = op.status;
            if (op.ins) begin
                count_next = count_reg + 1'b1;
            end else if (op.rem) begin
                count_next = count_reg - 1'b1;
            end
            if (op.rem) begin
                pop_value_next = read_value;
            end else if (op.status == fmbq_pkg::ST_EMPTY) begin
                pop_value_next = '1;
            end else begin
                pop_value_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pop_value_reg <= pop_value_next;
        status_reg    <= status_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_pop_value = pop_value_reg;
    assign m_status    = status_reg;

endmodule
